### rtl/swc_pkg.sv
package swc_pkg;

  // widths of the symbol fields
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned WID_W     = 4;
  localparam int unsigned MAX_WIDTH = 8;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // register indexes
  localparam logic REG_IN_WIDTH  = 1'b0;
  localparam logic REG_OUT_WIDTH = 1'b1;

  // one queued job: a word and how to emit it
  typedef struct packed {
    logic [SYM_W-1:0] word;
    logic [WID_W-1:0] nres;     // results to emit, 1..8
    logic [WID_W-1:0] wo;       // slice width when splitting
    logic             pass;     // emit word unchanged
    logic             blk_end;
  } swc_entry_t;

  // out-of-range widths: 0 acts as 1, above max acts as max
  function automatic logic [WID_W-1:0] clamp_f(input logic [WID_W-1:0] w);
    logic [WID_W-1:0] r;
    r = w;
    if (w == '0) begin
      r = WID_W'(1);
    end else if (w > WID_W'(MAX_WIDTH)) begin
      r = WID_W'(MAX_WIDTH);
    end
    return r;
  endfunction

  // truncated big/small for widths 1..8: largest k with k*small <= big
  function automatic logic [WID_W-1:0] ratio_f(input logic [WID_W-1:0] big,
                                                input logic [WID_W-1:0] small_w);
    logic [WID_W-1:0] r;
    logic [7:0]       prod;
    r = WID_W'(1);
    for (int k = 1; k <= MAX_WIDTH; k++) begin
      prod = 8'(small_w) * 8'(k);
      if (prod <= 8'(big)) begin
        r = WID_W'(k);
      end
    end
    return r;
  endfunction

  // low w bits set, w in 1..8
  function automatic logic [SYM_W-1:0] mask_f(input logic [WID_W-1:0] w);
    logic [WID_W-1:0] sh;
    sh = WID_W'(SYM_W) - w;
    return {SYM_W{1'b1}} >> sh;
  endfunction

endpackage

### rtl/swc_front.sv
module swc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [swc_pkg::WID_W-1:0] in_width_i,
  input  logic [swc_pkg::WID_W-1:0] out_width_i,
  input  logic                     cfg_clr_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [swc_pkg::SYM_W-1:0] symbol_in_i,
  input  logic                     block_end_in_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output swc_pkg::swc_entry_t      push_entry_o
);
  import swc_pkg::*;

  logic [SYM_W-1:0] gword_q, gword_d;
  logic [2:0]       gcnt_q, gcnt_d;

  logic [WID_W-1:0] wi, wo, ratio, cnt_eff, new_cnt, sh_n;
  logic [SYM_W-1:0] word_eff, new_word, piece;
  logic [7:0]       sh;
  logic             mode_eq, mode_split, complete, accept;

  // classify by clamped widths
  always_comb begin
    wi         = clamp_f(in_width_i);
    wo         = clamp_f(out_width_i);
    mode_eq    = (wi == wo);
    mode_split = (wi > wo);
    ratio      = mode_split ? ratio_f(wi, wo) : ratio_f(wo, wi);
  end

  // gather path; a stale count restarts the group
  always_comb begin
    if (WID_W'(gcnt_q) >= ratio) begin
      cnt_eff  = '0;
      word_eff = '0;
    end else begin
      cnt_eff  = WID_W'(gcnt_q);
      word_eff = gword_q;
    end
    sh_n     = ratio - cnt_eff - WID_W'(1);
    sh       = 8'(sh_n) * 8'(wi);
    piece    = symbol_in_i & mask_f(wi);
    new_word = word_eff | (piece << sh);
    new_cnt  = cnt_eff + WID_W'(1);
    complete = (new_cnt == ratio);
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // queue entry for this beat
  always_comb begin
    push_entry_o.blk_end = block_end_in_i;
    push_entry_o.wo      = wo;
    if (mode_eq) begin
      push_entry_o.word = symbol_in_i;
      push_entry_o.nres = WID_W'(1);
      push_entry_o.pass = 1'b1;
      push_o            = accept;
    end else if (mode_split) begin
      push_entry_o.word = symbol_in_i;
      push_entry_o.nres = ratio;
      push_entry_o.pass = 1'b0;
      push_o            = accept;
    end else begin
      push_entry_o.word = new_word;
      push_entry_o.nres = WID_W'(1);
      push_entry_o.pass = 1'b1;
      push_o            = accept && complete;
    end
  end

  // gatherer update
  always_comb begin
    gword_d = gword_q;
    gcnt_d  = gcnt_q;
    if (cfg_clr_i) begin
      gword_d = '0;
      gcnt_d  = '0;
    end else if (accept && !mode_eq && !mode_split) begin
      if (complete || block_end_in_i) begin
        gword_d = '0;
        gcnt_d  = '0;
      end else begin
        gword_d = new_word;
        gcnt_d  = new_cnt[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gword_q <= '0;
      gcnt_q  <= '0;
    end else begin
      gword_q <= gword_d;
      gcnt_q  <= gcnt_d;
    end
  end

endmodule

### rtl/swc_fifo.sv
module swc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  swc_pkg::swc_entry_t push_entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output swc_pkg::swc_entry_t pop_entry_o
);
  import swc_pkg::*;

  swc_entry_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o     = (cnt_q == '0);
  assign pop_entry_o = mem_q[rd_q];

  // pointers and fill level
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule

### rtl/swc_back.sv
module swc_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_empty_i,
  input  swc_pkg::swc_entry_t      q_entry_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [swc_pkg::SYM_W-1:0] symbol_out_o,
  output logic                     run_last_o,
  output logic                     block_end_out_o
);
  import swc_pkg::*;

  swc_entry_t       cur_q, cur_d;
  logic [WID_W-1:0] rem_q, rem_d, rem_m1;
  logic             busy_q, busy_d, accept, last;
  logic [7:0]       sh;

  assign accept = busy_q && !out_stall_i;
  assign last   = (rem_q == WID_W'(1));
  assign pop_o  = !q_empty_i && (!busy_q || (accept && last));

  // slice select, top part first
  always_comb begin
    rem_m1 = rem_q - WID_W'(1);
    sh     = 8'(rem_m1) * 8'(cur_q.wo);
    if (cur_q.pass) begin
      symbol_out_o = cur_q.word;
    end else begin
      symbol_out_o = (cur_q.word >> sh) & mask_f(cur_q.wo);
    end
  end

  assign out_valid_o     = busy_q;
  assign run_last_o      = last;
  assign block_end_out_o = last && cur_q.blk_end;

  // beat counter and job load
  always_comb begin
    cur_d  = cur_q;
    rem_d  = rem_q;
    busy_d = busy_q;
    if (pop_o) begin
      cur_d  = q_entry_i;
      rem_d  = q_entry_i.nres;
      busy_d = 1'b1;
    end else if (accept) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        rem_d = rem_m1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

### rtl/symbol_width_converter.sv
// A completing input beat is stored in the queue, then loaded into the output stage.
// Throughput: one result beat per cycle while out_stall_i is low; an input that splits
// into N results holds the output stage for N slices, emitted one per cycle.
// Equal widths and gathering sustain one input beat per cycle unless the output stalls.
// Reset: in_width 1, out_width 8, gatherer, queue and output stage empty.
module symbol_width_converter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // config port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [swc_pkg::SYM_W-1:0] symbol_in_i,
  input  logic                      block_end_in_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [swc_pkg::SYM_W-1:0] symbol_out_o,
  output logic                      run_last_o,
  output logic                      block_end_out_o
);
  import swc_pkg::*;

  logic [WID_W-1:0] in_width_q, in_width_d, out_width_q, out_width_d;
  logic             wr_en;
  logic             push, pop, q_full, q_empty;
  swc_entry_t       push_entry, pop_entry;

  // register file
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    in_width_d  = in_width_q;
    out_width_d = out_width_q;
    if (wr_en) begin
      case (paddr[2])
        REG_IN_WIDTH:  in_width_d  = pwdata[WID_W-1:0];
        REG_OUT_WIDTH: out_width_d = pwdata[WID_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IN_WIDTH:  prdata = 32'(in_width_q);
      REG_OUT_WIDTH: prdata = 32'(out_width_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q  <= WID_W'(1);
      out_width_q <= WID_W'(8);
    end else begin
      in_width_q  <= in_width_d;
      out_width_q <= out_width_d;
    end
  end

  swc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_width_i     (in_width_q),
    .out_width_i    (out_width_q),
    .cfg_clr_i      (wr_en),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .symbol_in_i    (symbol_in_i),
    .block_end_in_i (block_end_in_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_entry_o   (push_entry)
  );

  swc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .empty_o      (q_empty),
    .pop_entry_o  (pop_entry)
  );

  swc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_entry_i       (pop_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .symbol_out_o    (symbol_out_o),
    .run_last_o      (run_last_o),
    .block_end_out_o (block_end_out_o)
  );

endmodule
